// ===== rtl/core/shifting_array_table_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the shifting array table unit
// Concurrent assertion shorthands used by the top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef SHIFTING_ARRAY_TABLE_UNIT_MACROS_SVH
`define SHIFTING_ARRAY_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define SAT_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sat_pkg.sv =====
// ---------------------------------------------------------------------------
// Shifting array table package
// Shared widths, codes and types for the list cells and the top level.
// ---------------------------------------------------------------------------
package sat_pkg;

    localparam int DEPTH_DEFAULT      = 256;
    localparam int WORD_WIDTH_DEFAULT = 32;

    localparam int ACTION_W   = 4;
    localparam int POS_W      = 9;
    localparam int WORD_IN_W  = 32;
    localparam int WORD_OUT_W = 32;
    localparam int STATUS_W   = 2;
    localparam int USED_W     = 9;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [ACTION_W-1:0] {
        ACT_GET          = 4'd0,
        ACT_SET          = 4'd1,
        ACT_APPEND       = 4'd2,
        ACT_INSERT       = 4'd3,
        ACT_DELETE_AT    = 4'd4,
        ACT_DELETE_VALUE = 4'd5,
        ACT_CONTAINS     = 4'd6,
        ACT_POP          = 4'd7,
        ACT_CLEAR        = 4'd8
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        STATE_IDLE = 1'b0,
        STATE_RUN  = 1'b1
    } state_t;

    // flags traveling with the request token along the chain
    typedef struct packed {
        logic valid;
        logic removing;
        logic found;
    } token_t;

    // request command broadcast to all cells
    typedef struct packed {
        action_t act;
        logic    en;
    } cmd_t;

endpackage

// ===== rtl/core/shifting_array_table_unit.sv =====
// A new request is not taken until the last one is done: the request token
// walks the cell chain one cell per cycle, the result register loads, and
// the next request is taken once that result is accepted.
// Reset: clears the entry count, the token flags and the control state;
// list entries are undefined until written.
// ---------------------------------------------------------------------------
// Shifting array table unit
// Ordered word list with get, set, append, insert, delete, search, pop and
// clear, built as a chain of entry cells walked by a request token.
// ---------------------------------------------------------------------------
`include "shifting_array_table_unit_macros.svh"

module shifting_array_table_unit #(
    parameter int DEPTH      = sat_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = sat_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // action[3:0], position[12:4], word_in[44:13], zero[47:45]
    input  logic [sat_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // word_out[31:0], found[32], status[34:33], entries_used[43:35], zero[47:44]
    output logic [sat_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > sat_pkg::POS_W) ? CW : sat_pkg::POS_W;

    sat_pkg::state_t    state_reg, state_next;
    sat_pkg::action_t   act_reg;
    logic               en_reg;
    logic [CMP_W-1:0]   pos_reg;
    logic [WORD_WIDTH-1:0] word_reg;
    sat_pkg::status_t   status_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic               launch_reg;
    logic               m_valid_reg, m_valid_next;
    logic [sat_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    sat_pkg::action_t   s_action;
    logic [CMP_W-1:0]   s_pos;
    logic [WORD_WIDTH-1:0] s_word;
    logic [CMP_W-1:0]   cnt_ext;
    sat_pkg::status_t   s_status;
    logic               full;
    logic               accept;
    logic               load_out;
    logic [CW-1:0]      count_after;
    logic [CMP_W-1:0]   used_wide;
    logic [sat_pkg::WORD_OUT_W-1:0] wout_32;
    sat_pkg::cmd_t      cmd;

    sat_pkg::token_t       tok   [DEPTH+1];
    logic [WORD_WIDTH-1:0] carry [DEPTH+1];
    logic [WORD_WIDTH-1:0] wout  [DEPTH+1];
    logic [WORD_WIDTH-1:0] entry [DEPTH];
    logic [DEPTH:0]        tok_valid_vec;
    sat_pkg::token_t       exit_tok;

    assign s_action = sat_pkg::action_t'(s_tdata[3:0]);
    assign s_pos    = CMP_W'(s_tdata[12:4]);
    assign cnt_ext  = CMP_W'(count_reg);
    assign full     = (count_reg == CW'(DEPTH));

    generate
        if (WORD_WIDTH > sat_pkg::WORD_IN_W) begin : g_win_ext
            assign s_word = {{(WORD_WIDTH - sat_pkg::WORD_IN_W){1'b0}}, s_tdata[44:13]};
        end else begin : g_win_cut
            assign s_word = s_tdata[13 +: WORD_WIDTH];
        end
        if (WORD_WIDTH >= sat_pkg::WORD_OUT_W) begin : g_wout_cut
            assign wout_32 = wout[DEPTH][sat_pkg::WORD_OUT_W-1:0];
        end else begin : g_wout_ext
            assign wout_32 = {{(sat_pkg::WORD_OUT_W - WORD_WIDTH){1'b0}}, wout[DEPTH]};
        end
    endgenerate

    always_comb begin
        s_status = sat_pkg::STATUS_OK;
        unique case (s_action) inside
            sat_pkg::ACT_GET, sat_pkg::ACT_SET, sat_pkg::ACT_DELETE_AT: begin
                if (s_pos >= cnt_ext) s_status = sat_pkg::STATUS_RANGE;
            end
            sat_pkg::ACT_APPEND: begin
                if (full) s_status = sat_pkg::STATUS_FULL;
            end
            sat_pkg::ACT_INSERT: begin
                if (s_pos > cnt_ext) begin
                    s_status = sat_pkg::STATUS_RANGE;
                end else if (full) begin
                    s_status = sat_pkg::STATUS_FULL;
                end
            end
            sat_pkg::ACT_POP: begin
                if (count_reg == '0) s_status = sat_pkg::STATUS_EMPTY;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sat_pkg::STATE_IDLE: begin
                if (accept) state_next = sat_pkg::STATE_RUN;
            end
            sat_pkg::STATE_RUN: begin
                if (exit_tok.valid) state_next = sat_pkg::STATE_IDLE;
            end
            default: state_next = sat_pkg::STATE_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            sat_pkg::STATE_IDLE: s_tready = !m_valid_reg || m_tready;
            sat_pkg::STATE_RUN:  load_out = exit_tok.valid;
            default: begin
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        count_after = count_reg;
        if (en_reg) begin
            case (act_reg) inside
                sat_pkg::ACT_APPEND, sat_pkg::ACT_INSERT:
                    count_after = count_reg + CW'(1);
                sat_pkg::ACT_DELETE_AT, sat_pkg::ACT_POP:
                    count_after = count_reg - CW'(1);
                sat_pkg::ACT_DELETE_VALUE: begin
                    if (exit_tok.found) count_after = count_reg - CW'(1);
                end
                sat_pkg::ACT_CLEAR:
                    count_after = '0;
                default: begin
                end
            endcase
        end
    end

    assign used_wide   = CMP_W'(count_after);
    assign count_next  = load_out ? count_after : count_reg;
    assign m_data_next = {4'b0000, used_wide[sat_pkg::USED_W-1:0], status_reg,
                          exit_tok.found, wout_32};
    assign m_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sat_pkg::STATE_IDLE;
            count_reg   <= '0;
            launch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            launch_reg  <= accept;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg    <= s_action;
            en_reg     <= (s_status == sat_pkg::STATUS_OK);
            pos_reg    <= s_pos;
            word_reg   <= s_word;
            status_reg <= s_status;
        end
        if (load_out) begin
            m_data_reg <= m_data_next;
        end
    end

    assign cmd = '{act: act_reg, en: en_reg};

    assign tok[0]   = '{valid: launch_reg, removing: 1'b0, found: 1'b0};
    assign carry[0] = word_reg;
    assign wout[0]  = '0;
    assign exit_tok = tok[DEPTH];

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            logic [WORD_WIDTH-1:0] nbr;
            if (i == DEPTH - 1) begin : g_tail
                assign nbr = '0;
            end else begin : g_body
                assign nbr = entry[i+1];
            end
            sat_cell #(
                .WORD_WIDTH (WORD_WIDTH),
                .CMP_W      (CMP_W),
                .IDX        (i)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd_i   (cmd),
                .pos_i   (pos_reg),
                .count_i (cnt_ext),
                .word_i  (word_reg),
                .tok_i   (tok[i]),
                .carry_i (carry[i]),
                .wout_i  (wout[i]),
                .nbr_i   (nbr),
                .tok_o   (tok[i+1]),
                .carry_o (carry[i+1]),
                .wout_o  (wout[i+1]),
                .entry_o (entry[i])
            );
        end
        for (genvar j = 0; j <= DEPTH; j++) begin : g_tok_vec
            assign tok_valid_vec[j] = tok[j].valid;
        end
    endgenerate

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `SAT_ASSERT_IMPLIES(a_count_max, aclk, aresetn,
        1'b1, count_reg <= CW'(DEPTH), "count above depth")
    `SAT_ASSERT_IMPLIES(a_one_token, aclk, aresetn,
        1'b1, $onehot0(tok_valid_vec), "multiple tokens")
    `SAT_ASSERT_IMPLIES(a_exit_run, aclk, aresetn,
        exit_tok.valid, state_reg == sat_pkg::STATE_RUN, "token exit outside run")
    `SAT_ASSERT_IMPLIES(a_accept_empty, aclk, aresetn,
        accept, tok_valid_vec == '0, "accept with token in chain")
    `SAT_ASSERT_NEXT(a_count_hold, aclk, aresetn,
        !load_out, $stable(count_reg), "count changed without result")

endmodule

// ===== rtl/core/sat_cell.sv =====
// ---------------------------------------------------------------------------
// Shifting array table cell
// Holds one list entry and acts on the request token as it passes by.
// ---------------------------------------------------------------------------
module sat_cell #(
    parameter int WORD_WIDTH = sat_pkg::WORD_WIDTH_DEFAULT,
    parameter int CMP_W      = sat_pkg::POS_W,
    parameter int IDX        = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sat_pkg::cmd_t         cmd_i,
    input  logic [CMP_W-1:0]      pos_i,
    input  logic [CMP_W-1:0]      count_i,
    input  logic [WORD_WIDTH-1:0] word_i,
    input  sat_pkg::token_t       tok_i,
    input  logic [WORD_WIDTH-1:0] carry_i,
    input  logic [WORD_WIDTH-1:0] wout_i,
    input  logic [WORD_WIDTH-1:0] nbr_i,
    output sat_pkg::token_t       tok_o,
    output logic [WORD_WIDTH-1:0] carry_o,
    output logic [WORD_WIDTH-1:0] wout_o,
    output logic [WORD_WIDTH-1:0] entry_o
);

    localparam logic [CMP_W-1:0] MY_IDX      = CMP_W'(IDX);
    localparam logic [CMP_W-1:0] MY_IDX_NEXT = CMP_W'(IDX + 1);

    logic [WORD_WIDTH-1:0] entry_reg, entry_next;
    logic [WORD_WIDTH-1:0] carry_reg, carry_next;
    logic [WORD_WIDTH-1:0] wout_reg, wout_next;
    sat_pkg::token_t       tok_reg, tok_next;

    logic hit_pos;
    logic in_list;
    logic below_last;
    logic at_end;
    logic is_last;
    logic in_shift;
    logic match;
    logic start;
    logic removing;

    assign hit_pos    = (MY_IDX == pos_i);
    assign in_list    = (MY_IDX < count_i);
    assign below_last = (MY_IDX_NEXT < count_i);
    assign at_end     = (MY_IDX == count_i);
    assign is_last    = (MY_IDX_NEXT == count_i);
    assign in_shift   = (MY_IDX >= pos_i) && (MY_IDX <= count_i);
    assign match      = (entry_reg == word_i);

    always_comb begin
        tok_next   = tok_i;
        carry_next = carry_i;
        wout_next  = wout_i;
        entry_next = entry_reg;
        start      = 1'b0;
        removing   = tok_i.removing;
        if (tok_i.valid && cmd_i.en) begin
            case (cmd_i.act) inside
                sat_pkg::ACT_GET: begin
                    if (hit_pos) wout_next = entry_reg;
                end
                sat_pkg::ACT_SET: begin
                    if (hit_pos) begin
                        wout_next  = entry_reg;
                        entry_next = word_i;
                    end
                end
                sat_pkg::ACT_APPEND: begin
                    if (at_end) entry_next = word_i;
                end
                sat_pkg::ACT_INSERT: begin
                    // entry moves up one place, carried word drops in
                    if (in_shift) begin
                        entry_next = carry_i;
                        carry_next = entry_reg;
                    end
                end
                sat_pkg::ACT_DELETE_AT, sat_pkg::ACT_DELETE_VALUE: begin
                    if (cmd_i.act == sat_pkg::ACT_DELETE_AT) begin
                        start = hit_pos;
                    end else begin
                        start = !tok_i.removing && in_list && match;
                    end
                    removing = tok_i.removing || start;
                    if (start) begin
                        wout_next      = entry_reg;
                        tok_next.found = (cmd_i.act == sat_pkg::ACT_DELETE_VALUE);
                    end
                    tok_next.removing = removing;
                    // right neighbor is not yet touched by the token
                    if (removing && below_last) entry_next = nbr_i;
                end
                sat_pkg::ACT_CONTAINS: begin
                    if (in_list && match) tok_next.found = 1'b1;
                end
                sat_pkg::ACT_POP: begin
                    if (is_last) wout_next = entry_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        carry_reg <= carry_next;
        wout_reg  <= wout_next;
    end

    assign tok_o   = tok_reg;
    assign carry_o = carry_reg;
    assign wout_o  = wout_reg;
    assign entry_o = entry_reg;

endmodule

// ===== tb/tb_shifting_array_table_unit.sv =====
// ---------------------------------------------------------------------------
// Shifting array table unit testbench
// Drives list requests on the input stream and checks each result against a
// behavioral list kept in the bench, or a typed row's own values. A directed
// table covers the empty, out-of-range and unused-code cases first. Random
// segments follow, biased toward a target length so that the list fills to
// DEPTH, drains, and hovers near empty. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module tb_shifting_array_table_unit;

    import sat_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 680;
    localparam int LONG_HOLD    = 3000;
    localparam int STALL_LIMIT  = 20000;
    localparam int MAX_PRINTS   = 30;

    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [ACTION_W-1:0]  act;
        logic [POS_W-1:0]     pos;
        logic [WORD_IN_W-1:0] word;
    } list_req_t;

    typedef struct packed {
        logic [WORD_OUT_W-1:0] word;
        logic                  found;
        status_t               status;
        logic [USED_W-1:0]     used;
    } list_result_t;

    typedef struct packed {
        logic [ACTION_W-1:0]   act;
        logic [POS_W-1:0]      pos;
        logic [WORD_IN_W-1:0]  word;
        logic                  typed;
        logic [WORD_OUT_W-1:0] e_word;
        logic                  e_found;
        status_t               e_status;
        logic [USED_W-1:0]     e_used;
    } directed_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [WORD_IN_W-1:0] list_mem [DEPTH];
    int                   list_len = 0;
    list_result_t         pending_results [$];
    int                   err_count = 0;
    int                   hold_off_asked = 0;

    shifting_array_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- list behavior ----------------

    function automatic int find_value(input logic [WORD_IN_W-1:0] word);
        for (int i = 0; i < list_len; i++) begin
            if (list_mem[i] == word) return i;
        end
        return -1;
    endfunction

    function automatic void drop_entry(input int idx);
        for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
        list_len--;
    endfunction

    function automatic list_result_t apply_list_op(input list_req_t req);
        list_result_t res;
        int           hit;
        res = '0;
        res.status = STATUS_OK;
        case (req.act)
            ACT_GET: begin
                if (req.pos >= list_len) res.status = STATUS_RANGE;
                else res.word = list_mem[req.pos];
            end
            ACT_SET: begin
                if (req.pos >= list_len) begin
                    res.status = STATUS_RANGE;
                end else begin
                    res.word = list_mem[req.pos];
                    list_mem[req.pos] = req.word;
                end
            end
            ACT_APPEND: begin
                if (list_len >= DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    list_mem[list_len] = req.word;
                    list_len++;
                end
            end
            ACT_INSERT: begin
                if (req.pos > list_len) begin
                    res.status = STATUS_RANGE;
                end else if (list_len >= DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    for (int i = list_len; i > req.pos; i--) list_mem[i] = list_mem[i - 1];
                    list_mem[req.pos] = req.word;
                    list_len++;
                end
            end
            ACT_DELETE_AT: begin
                if (req.pos >= list_len) begin
                    res.status = STATUS_RANGE;
                end else begin
                    res.word = list_mem[req.pos];
                    drop_entry(int'(req.pos));
                end
            end
            ACT_DELETE_VALUE: begin
                hit = find_value(req.word);
                if (hit >= 0) begin
                    res.word  = list_mem[hit];
                    res.found = 1'b1;
                    drop_entry(hit);
                end
            end
            ACT_CONTAINS: res.found = (find_value(req.word) >= 0);
            ACT_POP: begin
                if (list_len == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.word = list_mem[list_len - 1];
                    list_len--;
                end
            end
            ACT_CLEAR: list_len = 0;
            default: ;
        endcase
        res.used = USED_W'(list_len);
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [WORD_IN_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 4) return WORD_IN_W'($urandom_range(0, 7));
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(input int top);
        if (top >= 0 && $urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, top));
        return POS_W'($urandom_range(0, 511));
    endfunction

    function automatic logic [WORD_IN_W-1:0] pick_value();
        if (list_len > 0 && $urandom_range(0, 99) < 70)
            return list_mem[$urandom_range(0, list_len - 1)];
        return rand_word();
    endfunction

    // grows the list while below target, otherwise mostly shrinks or reads
    function automatic list_req_t next_request(input int target);
        list_req_t req;
        int        r;
        req.word = rand_word();
        req.pos  = pick_pos(list_len - 1);
        r = $urandom_range(0, 99);
        if (list_len < target) begin
            if (r < 45) req.act = ACT_APPEND;
            else if (r < 80) begin
                req.act = ACT_INSERT;
                req.pos = pick_pos(list_len);
            end
            else if (r < 88) req.act = ACT_GET;
            else if (r < 92) req.act = ACT_SET;
            else if (r < 96) begin
                req.act  = ACT_CONTAINS;
                req.word = pick_value();
            end
            else req.act = ACTION_W'($urandom_range(0, 15));
        end else begin
            if (r < 15) req.act = ACT_DELETE_AT;
            else if (r < 30) begin
                req.act  = ACT_DELETE_VALUE;
                req.word = pick_value();
            end
            else if (r < 40) req.act = ACT_POP;
            else if (r < 55) req.act = ACT_GET;
            else if (r < 68) req.act = ACT_SET;
            else if (r < 78) begin
                req.act  = ACT_CONTAINS;
                req.word = pick_value();
            end
            else if (r < 84) req.act = ACT_APPEND;
            else if (r < 90) begin
                req.act = ACT_INSERT;
                req.pos = pick_pos(list_len);
            end
            else if (r < 93) req.act = ACT_CLEAR;
            else req.act = ACTION_W'($urandom_range(0, 15));
        end
        return req;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 6);
        if (r < 97) return $urandom_range(7, 60);
        return $urandom_range(100, 400);
    endfunction

    task automatic issue(input list_req_t req, input int gap, input bit typed,
                         input list_result_t typed_res);
        list_result_t res;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 45){1'b0}}, req.word, req.pos, req.act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = apply_list_op(req);
        pending_results.push_back(typed ? typed_res : res);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom, $urandom});
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS) $display("%0t: %s", $time, msg);
    endtask

    // ---------------- directed requests ----------------

    directed_row_t directed_rows [$] = '{
        '{ACT_GET,          9'd0,   32'h0,         1'b1, 32'h0,         1'b0, STATUS_RANGE, 9'd0},
        '{ACT_POP,          9'd0,   32'h0,         1'b1, 32'h0,         1'b0, STATUS_EMPTY, 9'd0},
        '{ACT_DELETE_AT,    9'd0,   32'h0,         1'b1, 32'h0,         1'b0, STATUS_RANGE, 9'd0},
        '{ACT_DELETE_VALUE, 9'd0,   32'h0,         1'b1, 32'h0,         1'b0, STATUS_OK,    9'd0},
        '{ACT_CONTAINS,     9'd0,   32'hFFFF_FFFF, 1'b1, 32'h0,         1'b0, STATUS_OK,    9'd0},
        '{ACT_INSERT,       9'd1,   32'h5,         1'b1, 32'h0,         1'b0, STATUS_RANGE, 9'd0},
        '{ACT_APPEND,       9'd0,   32'hFFFF_FFFF, 1'b1, 32'h0,         1'b0, STATUS_OK,    9'd1},
        '{ACT_INSERT,       9'd0,   32'h0,         1'b1, 32'h0,         1'b0, STATUS_OK,    9'd2},
        '{ACT_INSERT,       9'd2,   32'h1234_5678, 1'b1, 32'h0,         1'b0, STATUS_OK,    9'd3},
        '{ACT_GET,          9'd1,   32'h0,         1'b1, 32'hFFFF_FFFF, 1'b0, STATUS_OK,    9'd3},
        '{ACT_GET,          9'd511, 32'h0,         1'b1, 32'h0,         1'b0, STATUS_RANGE, 9'd3},
        '{ACT_SET,          9'd256, 32'h0,         1'b1, 32'h0,         1'b0, STATUS_RANGE, 9'd3},
        '{ACT_INSERT,       9'd256, 32'h0,         1'b1, 32'h0,         1'b0, STATUS_RANGE, 9'd3},
        '{ACT_SET,          9'd0,   32'hA5A5_A5A5, 1'b1, 32'h0,         1'b0, STATUS_OK,    9'd3},
        '{ACT_APPEND,       9'd0,   32'hA5A5_A5A5, 1'b0, 32'h0,         1'b0, STATUS_OK,    9'd0},
        '{ACT_CONTAINS,     9'd0,   32'hA5A5_A5A5, 1'b0, 32'h0,         1'b0, STATUS_OK,    9'd0},
        '{ACT_DELETE_VALUE, 9'd0,   32'hA5A5_A5A5, 1'b0, 32'h0,         1'b0, STATUS_OK,    9'd0},
        '{ACT_CONTAINS,     9'd0,   32'h0,         1'b0, 32'h0,         1'b0, STATUS_OK,    9'd0},
        '{ACT_DELETE_AT,    9'd0,   32'h0,         1'b0, 32'h0,         1'b0, STATUS_OK,    9'd0},
        '{ACT_SPARE_LO,     9'd511, 32'hFFFF_FFFF, 1'b1, 32'h0,         1'b0, STATUS_OK,    9'd2},
        '{ACT_SPARE_HI,     9'd511, 32'hFFFF_FFFF, 1'b1, 32'h0,         1'b0, STATUS_OK,    9'd2},
        '{ACT_POP,          9'd0,   32'h0,         1'b0, 32'h0,         1'b0, STATUS_OK,    9'd0},
        '{ACT_DELETE_AT,    9'd1,   32'h0,         1'b1, 32'h0,         1'b0, STATUS_RANGE, 9'd1},
        '{ACT_CLEAR,        9'd0,   32'h0,         1'b1, 32'h0,         1'b0, STATUS_OK,    9'd0},
        '{ACT_POP,          9'd0,   32'h0,         1'b1, 32'h0,         1'b0, STATUS_EMPTY, 9'd0}
    };

    // ---------------- request side ----------------

    initial begin
        list_req_t    req;
        list_result_t want;
        int           issued;
        int           seg;
        int           seg_target;
        int           seg_len;
        int           r;
        bit           steady;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k]) begin
            req.act      = directed_rows[k].act;
            req.pos      = directed_rows[k].pos;
            req.word     = directed_rows[k].word;
            want.word    = directed_rows[k].e_word;
            want.found   = directed_rows[k].e_found;
            want.status  = directed_rows[k].e_status;
            want.used    = directed_rows[k].e_used;
            issue(req, idle_gap(), directed_rows[k].typed, want);
        end
        wait_for_results();

        // first segment fills the list to DEPTH and exercises the full case
        issued = 0;
        seg    = 0;
        while (issued < RANDOM_ITEMS) begin
            if (seg == 0) begin
                seg_target = DEPTH;
                seg_len    = 340;
            end else begin
                r = $urandom_range(0, 5);
                case (r)
                    0:       seg_target = 0;
                    1:       seg_target = 1;
                    2:       seg_target = 2;
                    3:       seg_target = 4;
                    4:       seg_target = $urandom_range(5, 16);
                    default: seg_target = 48;
                endcase
                seg_len = $urandom_range(20, 60);
            end
            steady = ($urandom_range(0, 3) == 0);
            repeat (seg_len) begin
                if (issued == 100) hold_off_asked++;
                if (issued == 450) wait_for_results();
                req = next_request(seg_target);
                issue(req, steady ? 0 : idle_gap(), 1'b0, '0);
                issued++;
            end
            seg++;
        end

        wait_for_results();
        repeat (2 * (DEPTH + 1)) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // ---------------- result side ----------------

    initial begin
        int hold_len;
        int run_len;
        int hold_off_served;
        int r;
        hold_off_served = 0;
        m_tready <= 1'b0;
        forever begin
            if (hold_off_asked != hold_off_served) begin
                hold_off_served++;
                hold_len = LONG_HOLD;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) hold_len = 0;
                else if (r < 90) hold_len = $urandom_range(1, 8);
                else if (r < 98) hold_len = $urandom_range(9, 100);
                else hold_len = $urandom_range(150, 500);
            end
            repeat (hold_len) begin
                @(posedge aclk);
                m_tready <= 1'b0;
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 1500)
                                                  : $urandom_range(1, 40);
            repeat (run_len) begin
                @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.word)
                    report_mismatch($sformatf("word_out %h, want %h", m_tdata[31:0], want.word));
                if (m_tdata[32] !== want.found)
                    report_mismatch($sformatf("found %b, want %b", m_tdata[32], want.found));
                if (m_tdata[34:33] !== want.status)
                    report_mismatch($sformatf("status %0d, want %s", m_tdata[34:33],
                                              want.status.name()));
                if (m_tdata[43:35] !== want.used)
                    report_mismatch($sformatf("entries_used %0d, want %0d", m_tdata[43:35],
                                              want.used));
            end
        end
    end

    // ---------------- watchdog ----------------

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
